// ----- rtl/pgsd_pkg.sv -----
// Shared types and constants for the packed grid stream decoder.
// Holds the state, phase, result-kind and error-code types and the header constants.
// Depends on nothing.
`timescale 1ns / 1ps

package pgsd_pkg;

  // Widest value that a header may ask for, and the value field width.
  localparam int MaxValueBits = 32;
  localparam int ValueW       = 32;
  localparam int VbitsW       = $clog2(MaxValueBits + 1);

  // Header layout: two magic bytes, width, height, bit width.
  localparam int          HdrLen   = 7;
  localparam logic [2:0]  HdrLastIdx = 3'(HdrLen - 1);
  localparam logic [7:0]  MagicT   = 8'h54;
  localparam logic [7:0]  MagicC   = 8'h43;

  // Stream phase kept between beats.
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DROP    = 2'd2
  } phase_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_HDR_OUT,
    ST_BITS,
    ST_FIN,
    ST_ERR
  } state_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_VALUE  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  // Error codes.
  typedef enum logic [2:0] {
    ERR_SHORT     = 3'd0,
    ERR_BAD_MAGIC = 3'd1,
    ERR_ZERO_DIM  = 3'd2,
    ERR_BAD_WIDTH = 3'd3,
    ERR_LENGTH    = 3'd4
  } err_t;

  // One result beat.
  typedef struct packed {
    kind_t              kind;
    logic [ValueW-1:0]  value;
    logic               missing;
    err_t               error_code;
    logic [15:0]        grid_width;
    logic [15:0]        grid_height;
    logic [7:0]         bit_width;
    logic               frame_done;
    logic               run_last;
  } res_t;

endpackage

// ----- rtl/packed_grid_stream_decoder.sv -----
// Top level of the packed grid stream decoder: header parser and bit-serial value unpacker.
// Uses the types and constants of pgsd_pkg.
`timescale 1ns / 1ps

// Usage
// The input channel (in_valid, in_stall, in_data_byte, in_last_byte) takes one stream
// byte per beat; in_last_byte marks the final byte of a frame. The result channel
// (out_valid, out_stall, out_*) gives header, value and error results, one per beat,
// with out_run_last on the last result that a given input byte caused.
// A header byte is checked in ST_HEAD and, when it yields a result, goes on to ST_HDR_OUT
// or ST_ERR; a valid header on a last byte gives its header result and then a length
// error. A dropped byte is discarded without a result. A payload byte is unpacked by
// one shift-and-compare unit, one bit per cycle while no result waits on a stalled
// output; the next byte can be taken once all its bits are done, earlier when the
// frame's final value ends early in the byte, and after any error result that follows.
// That one-bit-per-cycle shift loop sets the rate. A value result appears on the output
// register in the cycle after its final bit is consumed.
// The block holds in_stall high while it works on a byte. When the receiver stalls,
// the held result stays on the output and the unpacker waits before completing the
// next value. Synchronous reset returns the block to the header phase with no result
// pending. Values leave before the frame length is checked, so a frame whose results
// end in an error must be discarded by the consumer.
module packed_grid_stream_decoder
  import pgsd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_data_byte,
  input  logic                in_last_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_kind,
  output logic [ValueW-1:0]   out_value,
  output logic                out_missing,
  output logic [2:0]          out_error_code,
  output logic [15:0]         out_grid_width,
  output logic [15:0]         out_grid_height,
  output logic [7:0]          out_bit_width,
  output logic                out_frame_done,
  output logic                out_run_last
);

  state_t              state_r, state_nxt;
  phase_t              phase_r, phase_nxt;
  logic [2:0]          hdr_idx_r, hdr_idx_nxt;
  logic                magic_ok_r, magic_ok_nxt;
  logic [15:0]         width_r, width_nxt;
  logic [15:0]         height_r, height_nxt;
  logic [VbitsW-1:0]   vbits_r, vbits_nxt;
  logic [31:0]         vleft_r, vleft_nxt;
  logic [ValueW-1:0]   acc_r, acc_nxt;
  logic [VbitsW-1:0]   bcoll_r, bcoll_nxt;
  logic [7:0]          byte_r, byte_nxt;
  logic                last_r, last_nxt;
  logic [2:0]          bit_idx_r, bit_idx_nxt;
  err_t                err_r, err_nxt;
  logic                out_valid_r, out_valid_nxt;
  res_t                res_r, res_nxt;

  logic                slot_free;
  logic                load;
  logic                bad_hdr;
  err_t                hdr_err;
  logic [ValueW-1:0]   acc_step;
  logic [VbitsW-1:0]   bcoll_step;
  logic                val_done;
  logic [31:0]         vleft_dec;
  logic [ValueW-1:0]   vmask;
  logic                val_miss;

  // The output register can take a result when it is empty or being drained.
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);

  // Shift unit: one bit of the held byte into the accumulator.
  assign acc_step   = {acc_r[ValueW-2:0], byte_r[bit_idx_r]};
  assign bcoll_step = bcoll_r + VbitsW'(1);
  assign val_done   = (bcoll_step == vbits_r);
  assign vleft_dec  = vleft_r - 32'd1;
  assign vmask      = ValueW'(({{ValueW{1'b0}}, 1'b1} << vbits_r) - {{ValueW{1'b0}}, 1'b1});
  assign val_miss   = (acc_step == vmask);

  // Header checks, in priority order: magic, dimensions, bit width.
  always_comb begin
    bad_hdr = 1'b1;
    hdr_err = ERR_BAD_MAGIC;
    if (!magic_ok_r) begin
      hdr_err = ERR_BAD_MAGIC;
    end else if (width_r == 16'd0 || height_r == 16'd0) begin
      hdr_err = ERR_ZERO_DIM;
    end else if (byte_r == 8'd0 || byte_r > 8'(MaxValueBits)) begin
      hdr_err = ERR_BAD_WIDTH;
    end else begin
      bad_hdr = 1'b0;
    end
  end

  // Sequencer: next state, model state and the result to load.
  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    hdr_idx_nxt  = hdr_idx_r;
    magic_ok_nxt = magic_ok_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    vbits_nxt    = vbits_r;
    vleft_nxt    = vleft_r;
    acc_nxt      = acc_r;
    bcoll_nxt    = bcoll_r;
    byte_nxt     = byte_r;
    last_nxt     = last_r;
    bit_idx_nxt  = bit_idx_r;
    err_nxt      = err_r;
    load         = 1'b0;
    res_nxt      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          byte_nxt = in_data_byte;
          last_nxt = in_last_byte;
          case (phase_r)
            PH_HEADER: begin
              state_nxt = ST_HEAD;
            end
            PH_PAYLOAD: begin
              state_nxt   = ST_BITS;
              bit_idx_nxt = 3'd7;
            end
            default: begin
              if (in_last_byte) begin
                phase_nxt = PH_HEADER;
              end
            end
          endcase
        end
      end

      ST_HEAD: begin
        case (hdr_idx_r)
          3'd0: begin
            magic_ok_nxt = (byte_r == MagicT);
            width_nxt    = '0;
            height_nxt   = '0;
          end
          3'd1: magic_ok_nxt = magic_ok_r && (byte_r == MagicC);
          3'd2: width_nxt  = {8'd0, byte_r};
          3'd3: width_nxt  = {byte_r, width_r[7:0]};
          3'd4: height_nxt = {8'd0, byte_r};
          3'd5: height_nxt = {byte_r, height_r[7:0]};
          default: ;
        endcase
        if (hdr_idx_r != HdrLastIdx) begin
          if (last_r) begin
            err_nxt     = ERR_SHORT;
            hdr_idx_nxt = '0;
            state_nxt   = ST_ERR;
          end else begin
            hdr_idx_nxt = hdr_idx_r + 3'd1;
            state_nxt   = ST_IDLE;
          end
        end else begin
          hdr_idx_nxt = '0;
          if (bad_hdr) begin
            err_nxt   = hdr_err;
            phase_nxt = last_r ? PH_HEADER : PH_DROP;
            state_nxt = ST_ERR;
          end else begin
            vbits_nxt = VbitsW'(byte_r);
            vleft_nxt = width_r * height_r;
            acc_nxt   = '0;
            bcoll_nxt = '0;
            state_nxt = ST_HDR_OUT;
          end
        end
      end

      ST_HDR_OUT: begin
        if (slot_free) begin
          load                = 1'b1;
          res_nxt.kind        = KIND_HEADER;
          res_nxt.grid_width  = width_r;
          res_nxt.grid_height = height_r;
          res_nxt.bit_width   = byte_r;
          res_nxt.run_last    = !last_r;
          if (last_r) begin
            err_nxt   = ERR_LENGTH;
            phase_nxt = PH_HEADER;
            state_nxt = ST_ERR;
          end else begin
            phase_nxt = PH_PAYLOAD;
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_BITS: begin
        if (vleft_r == 32'd0) begin
          state_nxt = ST_FIN;
        end else if (!val_done || slot_free) begin
          if (val_done) begin
            acc_nxt            = '0;
            bcoll_nxt          = '0;
            vleft_nxt          = vleft_dec;
            load               = 1'b1;
            res_nxt.kind       = KIND_VALUE;
            res_nxt.value      = val_miss ? '1 : acc_step;
            res_nxt.missing    = val_miss;
            res_nxt.frame_done = (vleft_dec == 32'd0) && last_r;
            // Last of this byte unless another value fits in the remaining bits
            // or a length error follows.
            if (vleft_dec == 32'd0) begin
              res_nxt.run_last = last_r;
            end else begin
              res_nxt.run_last = !last_r && (vbits_r > VbitsW'(bit_idx_r));
            end
          end else begin
            acc_nxt   = acc_step;
            bcoll_nxt = bcoll_step;
          end
          if (bit_idx_r == 3'd0) begin
            state_nxt = ST_FIN;
          end else begin
            bit_idx_nxt = bit_idx_r - 3'd1;
          end
        end
      end

      ST_FIN: begin
        if (vleft_r == 32'd0) begin
          if (last_r) begin
            phase_nxt = PH_HEADER;
            state_nxt = ST_IDLE;
          end else begin
            err_nxt   = ERR_LENGTH;
            phase_nxt = PH_DROP;
            state_nxt = ST_ERR;
          end
        end else if (last_r) begin
          err_nxt   = ERR_LENGTH;
          phase_nxt = PH_HEADER;
          state_nxt = ST_ERR;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_ERR: begin
        if (slot_free) begin
          load               = 1'b1;
          res_nxt.kind       = KIND_ERROR;
          res_nxt.error_code = err_r;
          res_nxt.run_last   = 1'b1;
          state_nxt          = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output valid: set on load, cleared once the beat is taken.
  assign out_valid_nxt = load ? 1'b1 : (out_valid_r && out_stall);

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_HEADER;
      hdr_idx_r   <= '0;
      magic_ok_r  <= 1'b0;
      vbits_r     <= '0;
      vleft_r     <= '0;
      acc_r       <= '0;
      bcoll_r     <= '0;
      bit_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      hdr_idx_r   <= hdr_idx_nxt;
      magic_ok_r  <= magic_ok_nxt;
      vbits_r     <= vbits_nxt;
      vleft_r     <= vleft_nxt;
      acc_r       <= acc_nxt;
      bcoll_r     <= bcoll_nxt;
      bit_idx_r   <= bit_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Data registers.
  always_ff @(posedge clk) begin
    width_r  <= width_nxt;
    height_r <= height_nxt;
    byte_r   <= byte_nxt;
    last_r   <= last_nxt;
    err_r    <= err_nxt;
    if (load) begin
      res_r <= res_nxt;
    end
  end

  // Output ports.
  assign out_valid       = out_valid_r;
  assign out_kind        = res_r.kind;
  assign out_value       = res_r.value;
  assign out_missing     = res_r.missing;
  assign out_error_code  = res_r.error_code;
  assign out_grid_width  = res_r.grid_width;
  assign out_grid_height = res_r.grid_height;
  assign out_bit_width   = res_r.bit_width;
  assign out_frame_done  = res_r.frame_done;
  assign out_run_last    = res_r.run_last;

  // A missing value always reads as all ones.
  a_missing_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.kind == KIND_VALUE && res_r.missing) |-> (res_r.value == '1))
    else $error("missing value not all ones");

  // A completed frame ends the results of its byte.
  a_frame_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.frame_done) |-> (res_r.kind == KIND_VALUE && res_r.run_last))
    else $error("frame_done on a result that is not the last value of its byte");

  // An error result is always the last result of its byte.
  a_error_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.kind == KIND_ERROR) |-> res_r.run_last)
    else $error("error result without run_last");

  // Waiting for a payload byte means values remain.
  a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && phase_r == PH_PAYLOAD) |-> (vleft_r != 32'd0))
    else $error("payload phase with no values left");

  // Between bytes the partial value is shorter than one value.
  a_partial_short: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && phase_r == PH_PAYLOAD) |-> (bcoll_r < vbits_r))
    else $error("partial value not shorter than bit width");

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for packed_grid_stream_decoder: directed and random frames.
// Predicts every result beat and compares it field by field with the result channel.
// Depends on pgsd_pkg and the packed_grid_stream_decoder RTL.
`timescale 1ns / 1ps

module tb_top
  import pgsd_pkg::*;
();

  logic              clk             = 1'b0;
  logic              rst_n           = 1'b0;
  logic              in_valid        = 1'b0;
  logic [7:0]        in_data_byte    = 8'h00;
  logic              in_last_byte    = 1'b0;
  logic              out_stall       = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic [1:0]        out_kind;
  logic [ValueW-1:0] out_value;
  logic              out_missing;
  logic [2:0]        out_error_code;
  logic [15:0]       out_grid_width;
  logic [15:0]       out_grid_height;
  logic [7:0]        out_bit_width;
  logic              out_frame_done;
  logic              out_run_last;

  // When set, neither side inserts gaps or stalls.
  logic calm = 1'b0;

  int mismatches      = 0;
  int bytes_sent      = 0;
  int frames_sent     = 0;
  int results_checked = 0;

  // Expected result beats, oldest first.
  res_t expected_results[$];

  // Bytes of the frame that is being built.
  logic [7:0] frame_q[$];

  // Decoder state as the predictor sees it.
  phase_t      dec_phase      = PH_HEADER;
  logic [2:0]  hdr_count      = '0;
  logic [15:0] grid_w         = '0;
  logic [15:0] grid_h         = '0;
  int          bits_per_value = 0;
  logic [31:0] values_pending = '0;
  logic [31:0] shift_acc      = '0;
  int          shift_count    = 0;
  logic        magic_seen     = 1'b0;

  packed_grid_stream_decoder i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_value       (out_value),
    .out_missing     (out_missing),
    .out_error_code  (out_error_code),
    .out_grid_width  (out_grid_width),
    .out_grid_height (out_grid_height),
    .out_bit_width   (out_bit_width),
    .out_frame_done  (out_frame_done),
    .out_run_last    (out_run_last)
  );

  // Free-running clock with a 4 ns period.
  always #2 clk = ~clk;

  // The receiver stalls at random unless a calm stretch is running.
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 26);
  end

  // Builds one result beat; run_last is filled in once the byte is decoded.
  function automatic res_t make_result(kind_t k, logic [31:0] v, logic m, err_t e,
                                       logic [15:0] gw, logic [15:0] gh,
                                       logic [7:0] bw, logic done);
    res_t r;
    r.kind        = k;
    r.value       = v;
    r.missing     = m;
    r.error_code  = e;
    r.grid_width  = gw;
    r.grid_height = gh;
    r.bit_width   = bw;
    r.frame_done  = done;
    r.run_last    = 1'b0;
    return r;
  endfunction

  // Advances the predicted decoder by one accepted byte and queues its results.
  task automatic decode_stream_byte(input logic [7:0] b, input logic last);
    err_t        code;
    logic        bad;
    logic [31:0] mask;
    logic        miss;
    int          first;
    first = expected_results.size();
    if (dec_phase == PH_HEADER) begin
      case (hdr_count)
        3'd0: begin
          magic_seen = (b == MagicT);
          grid_w     = '0;
          grid_h     = '0;
        end
        3'd1: magic_seen = magic_seen && (b == MagicC);
        3'd2: grid_w = {8'h00, b};
        3'd3: grid_w[15:8] = b;
        3'd4: grid_h = {8'h00, b};
        3'd5: grid_h[15:8] = b;
        default: ;
      endcase
      if (hdr_count < HdrLastIdx) begin
        // A frame that ends inside the header is short.
        if (last) begin
          expected_results.push_back(make_result(KIND_ERROR, '0, 1'b0, ERR_SHORT,
                                                 '0, '0, '0, 1'b0));
          hdr_count = '0;
        end else begin
          hdr_count = hdr_count + 3'd1;
        end
      end else begin
        // Seventh byte: magic first, then dimensions, then bit width.
        hdr_count = '0;
        bad       = 1'b1;
        code      = ERR_SHORT;
        if (!magic_seen) code = ERR_BAD_MAGIC;
        else if (grid_w == 16'd0 || grid_h == 16'd0) code = ERR_ZERO_DIM;
        else if (b < 8'd1 || b > MaxValueBits) code = ERR_BAD_WIDTH;
        else bad = 1'b0;
        if (bad) begin
          expected_results.push_back(make_result(KIND_ERROR, '0, 1'b0, code,
                                                 '0, '0, '0, 1'b0));
          dec_phase = last ? PH_HEADER : PH_DROP;
        end else begin
          expected_results.push_back(make_result(KIND_HEADER, '0, 1'b0, ERR_SHORT,
                                                 grid_w, grid_h, b, 1'b0));
          bits_per_value = int'(b);
          values_pending = 32'(grid_w) * 32'(grid_h);
          shift_acc      = '0;
          shift_count    = 0;
          if (last) begin
            expected_results.push_back(make_result(KIND_ERROR, '0, 1'b0, ERR_LENGTH,
                                                   '0, '0, '0, 1'b0));
            dec_phase = PH_HEADER;
          end else begin
            dec_phase = PH_PAYLOAD;
          end
        end
      end
    end else if (dec_phase == PH_PAYLOAD) begin
      // Values are packed MSB first; pad bits after the final value are skipped.
      for (int i = 7; i >= 0 && values_pending != 0; i--) begin
        shift_acc   = {shift_acc[30:0], b[i]};
        shift_count = shift_count + 1;
        if (shift_count >= bits_per_value) begin
          mask           = 32'((64'd1 << bits_per_value) - 64'd1);
          miss           = (shift_acc == mask);
          values_pending = values_pending - 32'd1;
          expected_results.push_back(make_result(KIND_VALUE,
                                                 miss ? 32'hFFFF_FFFF : shift_acc,
                                                 miss, ERR_SHORT, '0, '0, '0,
                                                 values_pending == 0 && last));
          shift_acc   = '0;
          shift_count = 0;
        end
      end
      if (values_pending == 0) begin
        // Surplus bytes after the final value are a length error.
        if (last) begin
          dec_phase = PH_HEADER;
        end else begin
          expected_results.push_back(make_result(KIND_ERROR, '0, 1'b0, ERR_LENGTH,
                                                 '0, '0, '0, 1'b0));
          dec_phase = PH_DROP;
        end
      end else if (last) begin
        expected_results.push_back(make_result(KIND_ERROR, '0, 1'b0, ERR_LENGTH,
                                               '0, '0, '0, 1'b0));
        dec_phase = PH_HEADER;
      end
    end else begin
      // Dropping until the end of the frame.
      if (last) dec_phase = PH_HEADER;
    end
    if (expected_results.size() > first) begin
      expected_results[expected_results.size() - 1].run_last = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] seen);
    $display("MISMATCH at %0t: %s expected 0x%08h got 0x%08h", $realtime, what, want, seen);
    mismatches++;
  endtask

  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] seen);
    if (want !== seen) report_mismatch(what, want, seen);
  endtask

  // Every accepted result beat is checked against the oldest expectation.
  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, kind", '0, 32'(out_kind));
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        compare_field("kind", 32'(want.kind), 32'(out_kind));
        compare_field("value", want.value, out_value);
        compare_field("missing", 32'(want.missing), 32'(out_missing));
        compare_field("error_code", 32'(want.error_code), 32'(out_error_code));
        compare_field("grid_width", 32'(want.grid_width), 32'(out_grid_width));
        compare_field("grid_height", 32'(want.grid_height), 32'(out_grid_height));
        compare_field("bit_width", 32'(want.bit_width), 32'(out_bit_width));
        compare_field("frame_done", 32'(want.frame_done), 32'(out_frame_done));
        compare_field("run_last", 32'(want.run_last), 32'(out_run_last));
      end
    end
  end

  // Presents one byte at a falling edge and holds it until the beat is taken.
  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk);
    while (!calm && ($urandom_range(0, 99) < 26)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_stream_byte(b, last);
    bytes_sent++;
  endtask

  task automatic add_header(input logic [7:0] m0, input logic [7:0] m1,
                            input logic [15:0] w, input logic [15:0] h,
                            input logic [7:0] bw);
    frame_q.push_back(m0);
    frame_q.push_back(m1);
    frame_q.push_back(w[7:0]);
    frame_q.push_back(w[15:8]);
    frame_q.push_back(h[7:0]);
    frame_q.push_back(h[15:8]);
    frame_q.push_back(bw);
  endtask

  // Sends the built frame with the last flag on its final byte.
  task automatic flush_frame();
    for (int i = 0; i < frame_q.size(); i++) begin
      send_byte(frame_q[i], i == frame_q.size() - 1);
    end
    frame_q.delete();
    frames_sent++;
  endtask

  // Payload bytes lean toward all ones and all zeros so sentinels show up often.
  function automatic logic [7:0] pick_payload_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 8'hFF;
    if (r < 30) return 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  // Header failures, their priority, and a short frame.
  task automatic test_header_errors();
    frame_q.push_back(MagicT);
    flush_frame();
    // Bad magic wins over bad dimensions and width; the trailing byte is dropped.
    add_header(MagicC, MagicT, 16'h0000, 16'h0000, 8'h00);
    frame_q.push_back(8'hAA);
    flush_frame();
    add_header(MagicT, MagicC, 16'h0100, 16'h0000, 8'd32);
    flush_frame();
    add_header(MagicT, MagicC, 16'hFFFF, 16'hFFFF, 8'd33);
    flush_frame();
  endtask

  // A valid header on the final byte gives the header and then a length error.
  task automatic test_header_on_last();
    add_header(MagicT, MagicC, 16'hFFFF, 16'hFFFF, 8'd32);
    flush_frame();
  endtask

  // One-bit values with pad bits, and a full byte of values followed by surplus.
  task automatic test_payload_values();
    add_header(MagicT, MagicC, 16'd3, 16'd1, 8'd1);
    frame_q.push_back(8'hA0);
    flush_frame();
    add_header(MagicT, MagicC, 16'd8, 16'd1, 8'd1);
    frame_q.push_back(8'h5A);
    frame_q.push_back(8'h00);
    flush_frame();
  endtask

  // A frame that ends while a wide value is still incomplete.
  task automatic test_missing_bytes();
    add_header(MagicT, MagicC, 16'd1, 16'd1, 8'd32);
    frame_q.push_back(8'hFF);
    frame_q.push_back(8'hFF);
    flush_frame();
  endtask

  // Mostly well-formed frames with random content, the rest broken or noise.
  task automatic test_random_frames(input int byte_budget);
    int          stop_at;
    int          idx;
    int          r;
    int          sub;
    int          w;
    int          h;
    int          bw;
    int          nbytes;
    logic [7:0]  m0;
    logic [7:0]  m1;
    stop_at = bytes_sent + byte_budget;
    idx     = 0;
    while (bytes_sent < stop_at) begin
      calm = (idx >= 10 && idx < 22);
      r    = $urandom_range(0, 99);
      if (r < 70) begin
        w   = $urandom_range(1, 4);
        h   = $urandom_range(1, 3);
        sub = $urandom_range(0, 99);
        if (sub < 60) bw = $urandom_range(1, 8);
        else if (sub < 85) bw = $urandom_range(9, 16);
        else bw = $urandom_range(17, 32);
        nbytes = (w * h * bw + 7) / 8;
        add_header(MagicT, MagicC, 16'(w), 16'(h), 8'(bw));
        for (int i = 0; i < nbytes; i++) frame_q.push_back(pick_payload_byte());
        sub = $urandom_range(0, 99);
        if (sub < 10) begin
          // Truncate, possibly down to the header alone.
          repeat ($urandom_range(1, nbytes)) void'(frame_q.pop_back());
        end else if (sub < 20) begin
          repeat ($urandom_range(1, 3)) frame_q.push_back(pick_payload_byte());
        end
      end else if (r < 80) begin
        m0  = MagicT;
        m1  = MagicC;
        w   = $urandom_range(1, 300);
        h   = $urandom_range(1, 300);
        bw  = $urandom_range(1, 32);
        sub = $urandom_range(0, 2);
        if (sub == 0) begin
          if ($urandom_range(0, 1) == 0) begin
            m0 = 8'($urandom_range(0, 255));
            if (m0 == MagicT) m0 = m0 ^ 8'h01;
          end else begin
            m1 = 8'($urandom_range(0, 255));
            if (m1 == MagicC) m1 = m1 ^ 8'h80;
          end
          bw = $urandom_range(0, 255);
        end else if (sub == 1) begin
          case ($urandom_range(0, 2))
            0: w = 0;
            1: h = 0;
            default: begin
              w = 0;
              h = 0;
            end
          endcase
          bw = $urandom_range(0, 255);
        end else begin
          bw = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(33, 255);
        end
        add_header(m0, m1, 16'(w), 16'(h), 8'(bw));
        repeat ($urandom_range(0, 3)) frame_q.push_back(8'($urandom_range(0, 255)));
      end else if (r < 90) begin
        nbytes = $urandom_range(1, 6);
        frame_q.push_back(($urandom_range(0, 1) == 0) ? MagicT : 8'($urandom_range(0, 255)));
        for (int i = 1; i < nbytes; i++) begin
          frame_q.push_back((i == 1) ? MagicC : 8'($urandom_range(0, 255)));
        end
      end else begin
        repeat ($urandom_range(1, 10)) frame_q.push_back(8'($urandom_range(0, 255)));
      end
      flush_frame();
      idx++;
    end
    calm = 1'b0;
  endtask

  // Overall time limit for a hung block.
  initial begin
    #2_000_000;
    $display("packed_grid_stream_decoder verification failed");
    $finish;
  end

  // Reset, stimulus in turn, drain, then the verdict.
  initial begin
    int guard;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_header_errors();
    test_header_on_last();
    test_payload_values();
    test_missing_bytes();
    test_random_frames(400);

    @(negedge clk);
    in_valid <= 1'b0;
    guard = 0;
    while (expected_results.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    if (expected_results.size() != 0) begin
      report_mismatch("results never delivered, count", '0, 32'(expected_results.size()));
    end
    repeat (24) @(posedge clk);

    $display("Sent %0d bytes in %0d frames; checked %0d result beats.",
             bytes_sent, frames_sent, results_checked);
    $display("Frames covered header errors, short and surplus payloads and noise.");
    if (mismatches == 0) begin
      $display("packed_grid_stream_decoder verification clean");
    end else begin
      $display("packed_grid_stream_decoder verification failed");
    end
    $finish;
  end

endmodule
